// ===== hw/rtl/tmc_pkg.sv =====
// Package for the tracker motor controller: item and state types,
// direction, request and register index codes, register reset values.
// No dependencies.
`timescale 1ns / 1ps

package tmc_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned MV_W   = 12;
   localparam int unsigned MS_W   = 16;
   localparam int unsigned DUTY_W = 8;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic [1:0] dir_type;
   localparam dir_type DIR_STOP  = 2'd0;
   localparam dir_type DIR_LEFT  = 2'd1;
   localparam dir_type DIR_RIGHT = 2'd2;

   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_TIMER  = 2'd0;
   localparam req_kind_type REQ_AUTO   = 2'd1;
   localparam req_kind_type REQ_MANUAL = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_DEADBAND = 2'd0;
   localparam csr_index_type CSR_RUN_TIME = 2'd1;
   localparam csr_index_type CSR_HOLD_TIME = 2'd2;
   localparam csr_index_type CSR_DRIVE_DUTY = 2'd3;

   localparam logic [MV_W-1:0]   DEADBAND_RESET   = 12'd50;
   localparam logic [MS_W-1:0]   RUN_TIME_RESET   = 16'd500;
   localparam logic [MS_W-1:0]   HOLD_TIME_RESET  = 16'd3000;
   localparam logic [DUTY_W-1:0] DRIVE_DUTY_RESET = 8'd200;

   typedef struct packed {
      logic [MV_W-1:0]   deadband_mv;
      logic [MS_W-1:0]   run_time_ms;
      logic [MS_W-1:0]   hold_time_ms;
      logic [DUTY_W-1:0] drive_duty;
   } cfg_type;

   typedef struct packed {
      req_kind_type      req_type;
      logic [TIME_W-1:0] time_ms;
      logic [MV_W-1:0]   left_mv;
      logic [MV_W-1:0]   right_mv;
      logic              left_pressed;
      logic              right_pressed;
   } req_item_type;

   typedef struct packed {
      dir_type           direction;
      logic [DUTY_W-1:0] duty;
      logic              calib_request;
      logic              lockout_active;
   } rsp_item_type;

   typedef struct packed {
      dir_type           motor_dir;
      logic [TIME_W-1:0] stop_deadline;
      logic [TIME_W-1:0] hold_start;
      logic              hold_valid;
      logic              combo_lockout;
   } ctrl_state_type;

endpackage

// ===== hw/rtl/tmc_req_if.sv =====
// Request channel of the tracker motor controller: valid, ready and one item.
// Depends on tmc_pkg.
`timescale 1ns / 1ps

interface tmc_req_if;
   logic                  valid;
   logic                  ready;
   tmc_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tmc_rsp_if.sv =====
// Result channel of the tracker motor controller: valid, ready and one item.
// Depends on tmc_pkg.
`timescale 1ns / 1ps

interface tmc_rsp_if;
   logic                  valid;
   logic                  ready;
   tmc_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tmc_csr.sv =====
// Configuration registers of the tracker motor controller.
// Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  tmc_pkg::csr_index_type              csr_index,
   input  logic [tmc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tmc_pkg::cfg_type                    cfg
);

   tmc_pkg::cfg_type cfg_ff;
   tmc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tmc_pkg::CSR_DEADBAND: begin
               cfg_in.deadband_mv = csr_wdata[tmc_pkg::MV_W-1:0];
            end
            tmc_pkg::CSR_RUN_TIME: begin
               cfg_in.run_time_ms = csr_wdata[tmc_pkg::MS_W-1:0];
            end
            tmc_pkg::CSR_HOLD_TIME: begin
               cfg_in.hold_time_ms = csr_wdata[tmc_pkg::MS_W-1:0];
            end
            tmc_pkg::CSR_DRIVE_DUTY: begin
               cfg_in.drive_duty = csr_wdata[tmc_pkg::DUTY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_mv  <= tmc_pkg::DEADBAND_RESET;
         cfg_ff.run_time_ms  <= tmc_pkg::RUN_TIME_RESET;
         cfg_ff.hold_time_ms <= tmc_pkg::HOLD_TIME_RESET;
         cfg_ff.drive_duty   <= tmc_pkg::DRIVE_DUTY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/tmc_ctrl.sv =====
// Motor control state and its per-item update: timed stop, automatic
// turn, manual jog, both-button hold and lockout. Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  tmc_pkg::req_item_type item,
   input  tmc_pkg::cfg_type      cfg,
   output tmc_pkg::rsp_item_type rsp
);

   tmc_pkg::ctrl_state_type state_ff;
   tmc_pkg::ctrl_state_type state_in;

   logic [tmc_pkg::TIME_W-1:0] run_deadline;
   logic [tmc_pkg::TIME_W-1:0] hold_base;
   logic [tmc_pkg::TIME_W-1:0] hold_elapsed;
   logic                       hold_reached;
   logic                       deadline_hit;
   logic [tmc_pkg::MV_W:0]     left_limit;
   logic [tmc_pkg::MV_W:0]     right_limit;
   logic                       turn_left;
   logic                       turn_right;
   logic                       calib;

   assign run_deadline = item.time_ms
                         + {{(tmc_pkg::TIME_W-tmc_pkg::MS_W){1'b0}}, cfg.run_time_ms};
   assign deadline_hit = (state_ff.stop_deadline != '0)
                         && (item.time_ms >= state_ff.stop_deadline);

   assign left_limit  = {1'b0, item.right_mv} + {1'b0, cfg.deadband_mv};
   assign right_limit = {1'b0, item.left_mv} + {1'b0, cfg.deadband_mv};
   assign turn_left   = {1'b0, item.left_mv} > left_limit;
   assign turn_right  = {1'b0, item.right_mv} > right_limit;

   // A hold that starts on this poll has zero elapsed time.
   assign hold_base    = state_ff.hold_valid ? state_ff.hold_start : item.time_ms;
   assign hold_elapsed = item.time_ms - hold_base;
   assign hold_reached = hold_elapsed
                         >= {{(tmc_pkg::TIME_W-tmc_pkg::MS_W){1'b0}}, cfg.hold_time_ms};

   always_comb begin
      state_in = state_ff;
      calib    = 1'b0;
      case (item.req_type)
         tmc_pkg::REQ_TIMER: begin
            if (deadline_hit) begin
               state_in.motor_dir     = tmc_pkg::DIR_STOP;
               state_in.stop_deadline = '0;
            end
         end
         tmc_pkg::REQ_AUTO: begin
            if (turn_left) begin
               state_in.motor_dir     = tmc_pkg::DIR_LEFT;
               state_in.stop_deadline = run_deadline;
            end else if (turn_right) begin
               state_in.motor_dir     = tmc_pkg::DIR_RIGHT;
               state_in.stop_deadline = run_deadline;
            end else begin
               state_in.motor_dir     = tmc_pkg::DIR_STOP;
               state_in.stop_deadline = '0;
            end
         end
         tmc_pkg::REQ_MANUAL: begin
            if (state_ff.combo_lockout && (item.left_pressed || item.right_pressed)) begin
               state_in.motor_dir     = tmc_pkg::DIR_STOP;
               state_in.stop_deadline = '0;
            end else begin
               state_in.combo_lockout = 1'b0;
               state_in.stop_deadline = '0;
               if (item.left_pressed && item.right_pressed) begin
                  state_in.motor_dir = tmc_pkg::DIR_STOP;
                  if (hold_reached) begin
                     calib                  = 1'b1;
                     state_in.combo_lockout = 1'b1;
                     state_in.hold_valid    = 1'b0;
                  end else begin
                     state_in.hold_start = hold_base;
                     state_in.hold_valid = 1'b1;
                  end
               end else if (item.left_pressed) begin
                  state_in.hold_valid = 1'b0;
                  state_in.motor_dir  = tmc_pkg::DIR_LEFT;
               end else if (item.right_pressed) begin
                  state_in.hold_valid = 1'b0;
                  state_in.motor_dir  = tmc_pkg::DIR_RIGHT;
               end else begin
                  state_in.hold_valid = 1'b0;
                  state_in.motor_dir  = tmc_pkg::DIR_STOP;
               end
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   assign rsp.direction      = state_in.motor_dir;
   assign rsp.duty           = (state_in.motor_dir == tmc_pkg::DIR_STOP) ? '0 : cfg.drive_duty;
   assign rsp.calib_request  = calib;
   assign rsp.lockout_active = state_in.combo_lockout;

endmodule

// ===== hw/rtl/tracker_motor_controller_top.sv =====
// Top level of the tracker motor controller: input register, control state
// and result register. Depends on tmc_pkg, tmc_req_if, tmc_rsp_if, tmc_csr
// and tmc_ctrl.
//
// Usage: each item on req_chan is a timer update, an automatic sensor sample
// or a manual button poll; each gives exactly one item on rsp_chan with the
// motor direction, the duty, the calibration pulse and the lockout flag.
// Items are taken when valid and ready are both high.
// Each accepted item goes from the input register into the result register.
// Throughput: one item per cycle while rsp_chan.ready stays high; the two
// registers overlap, and the control state is updated as an item moves from
// the input register to the result register, so the next item always sees it.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that req_chan.ready drops.
// The csr_ port writes the four configuration registers; writes are meant to
// come while the block is idle.
// Reset is synchronous: both registers empty, motor stopped, no timed stop,
// no hold and no lockout, configuration at its default values.
`timescale 1ns / 1ps

module tracker_motor_controller_top (
   input  logic                                 clock,
   input  logic                                 reset,
   tmc_req_if.sink                              req_chan,
   tmc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  tmc_pkg::csr_index_type               csr_index,
   input  logic [tmc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   tmc_pkg::cfg_type      cfg;
   tmc_pkg::rsp_item_type step_rsp;

   logic                  in_vld_ff;
   logic                  in_vld_in;
   tmc_pkg::req_item_type in_item_ff;
   logic                  out_vld_ff;
   logic                  out_vld_in;
   tmc_pkg::rsp_item_type out_item_ff;
   logic                  advance;
   logic                  req_take;

   assign advance  = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_vld_ff || advance;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_chan.ready);

   tmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tmc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.data;
      end
      if (advance) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.data  = out_item_ff;

   a_calib_sets_lockout: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_item_ff.calib_request) |-> out_item_ff.lockout_active)
      else $error("calibration pulse without lockout");

   a_stop_has_no_duty: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_item_ff.direction == tmc_pkg::DIR_STOP))
      |-> (out_item_ff.duty == '0))
      else $error("stopped motor with nonzero duty");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while both registers are full and stalled");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("item moved on but result register is empty");

endmodule

// ===== bench/tracker_motor_controller_top_tb.sv =====
// Self-checking bench for tracker_motor_controller_top: directed and random
// items against a cycle-free predictor, with random idling and back-pressure.
// Depends on tmc_pkg, tmc_req_if, tmc_rsp_if and the controller RTL.
`timescale 1ns / 1ps

module tracker_motor_controller_top_tb;

   localparam tmc_pkg::req_kind_type REQ_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   tmc_pkg::csr_index_type csr_index;
   logic [tmc_pkg::CSR_DATA_W-1:0] csr_wdata;

   tmc_req_if req_chan ();
   tmc_rsp_if rsp_chan ();

   tracker_motor_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tmc_pkg::cfg_type        motor_cfg = '{tmc_pkg::DEADBAND_RESET, tmc_pkg::RUN_TIME_RESET,
                                          tmc_pkg::HOLD_TIME_RESET,
                                          tmc_pkg::DRIVE_DUTY_RESET};
   tmc_pkg::ctrl_state_type motor_model = '0;
   tmc_pkg::rsp_item_type   pending_motor_results [$];

   logic [tmc_pkg::TIME_W-1:0] sim_now = '0;
   int burst_left = 0;
   bit gaps_enabled = 1'b1;
   int rsp_hold_cycles = 0;

   int items_sent = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   int results_checked = 0;
   int mismatches = 0;
   int calib_seen = 0;
   int lockout_seen = 0;
   int input_stalls = 0;
   int settings_applied = 0;

   function automatic void halt_motor();
      motor_model.motor_dir = tmc_pkg::DIR_STOP;
      motor_model.stop_deadline = '0;
   endfunction

   function automatic tmc_pkg::rsp_item_type predict_motor_result(
         input tmc_pkg::req_item_type it);
      tmc_pkg::rsp_item_type r;
      logic calib;
      int diff;
      int band;
      logic [tmc_pkg::TIME_W-1:0] elapsed;
      calib = 1'b0;
      diff = int'(it.left_mv) - int'(it.right_mv);
      band = int'(motor_cfg.deadband_mv);
      case (it.req_type)
         tmc_pkg::REQ_TIMER: begin
            if (motor_model.stop_deadline != '0 && it.time_ms >= motor_model.stop_deadline)
               halt_motor();
         end
         tmc_pkg::REQ_AUTO: begin
            if (diff > band) begin
               motor_model.motor_dir = tmc_pkg::DIR_LEFT;
               motor_model.stop_deadline = it.time_ms
                                           + tmc_pkg::TIME_W'(motor_cfg.run_time_ms);
            end else if (-diff > band) begin
               motor_model.motor_dir = tmc_pkg::DIR_RIGHT;
               motor_model.stop_deadline = it.time_ms
                                           + tmc_pkg::TIME_W'(motor_cfg.run_time_ms);
            end else begin
               halt_motor();
            end
         end
         tmc_pkg::REQ_MANUAL: begin
            if (motor_model.combo_lockout && (it.left_pressed || it.right_pressed)) begin
               halt_motor();
            end else begin
               motor_model.combo_lockout = 1'b0;
               if (it.left_pressed && it.right_pressed) begin
                  halt_motor();
                  if (!motor_model.hold_valid) begin
                     motor_model.hold_start = it.time_ms;
                     motor_model.hold_valid = 1'b1;
                  end
                  elapsed = it.time_ms - motor_model.hold_start;
                  if (elapsed >= tmc_pkg::TIME_W'(motor_cfg.hold_time_ms)) begin
                     calib = 1'b1;
                     motor_model.combo_lockout = 1'b1;
                     motor_model.hold_valid = 1'b0;
                  end
               end else begin
                  motor_model.hold_valid = 1'b0;
                  if (it.left_pressed) begin
                     motor_model.motor_dir = tmc_pkg::DIR_LEFT;
                     motor_model.stop_deadline = '0;
                  end else if (it.right_pressed) begin
                     motor_model.motor_dir = tmc_pkg::DIR_RIGHT;
                     motor_model.stop_deadline = '0;
                  end else begin
                     halt_motor();
                  end
               end
            end
         end
         default: ;
      endcase
      r.direction = motor_model.motor_dir;
      r.duty = (motor_model.motor_dir == tmc_pkg::DIR_STOP) ? '0 : motor_cfg.drive_duty;
      r.calib_request = calib;
      r.lockout_active = motor_model.combo_lockout;
      return r;
   endfunction

   task automatic send_item(input tmc_pkg::req_item_type it);
      req_chan.valid <= 1'b1;
      req_chan.data <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_motor_results.push_back(predict_motor_result(it));
      items_sent++;
      kind_count[it.req_type]++;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_for_idle();
      req_chan.valid <= 1'b0;
      while (pending_motor_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [tmc_pkg::MV_W-1:0] band,
                                 input logic [tmc_pkg::MS_W-1:0] run,
                                 input logic [tmc_pkg::MS_W-1:0] hold,
                                 input logic [tmc_pkg::DUTY_W-1:0] duty);
      tmc_pkg::csr_index_type idx [4] = '{tmc_pkg::CSR_DEADBAND, tmc_pkg::CSR_RUN_TIME,
                                          tmc_pkg::CSR_HOLD_TIME,
                                          tmc_pkg::CSR_DRIVE_DUTY};
      logic [tmc_pkg::CSR_DATA_W-1:0] vals [4];
      vals[0] = tmc_pkg::CSR_DATA_W'(band);
      vals[1] = run;
      vals[2] = hold;
      vals[3] = tmc_pkg::CSR_DATA_W'(duty);
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      motor_cfg = '{band, run, hold, duty};
      settings_applied++;
   endtask

   task automatic check_field(input string name, input logic [31:0] expv,
                              input logic [31:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         mismatches++;
      end
   endtask

   task automatic check_result(input tmc_pkg::rsp_item_type got);
      tmc_pkg::rsp_item_type want;
      if (pending_motor_results.size() == 0) begin
         $display("%0t: result with nothing expected, expected none, actual %p",
                  $time, got);
         mismatches++;
      end else begin
         want = pending_motor_results.pop_front();
         check_field("direction", 32'(want.direction), 32'(got.direction));
         check_field("duty", 32'(want.duty), 32'(got.duty));
         check_field("calib_request", 32'(want.calib_request), 32'(got.calib_request));
         check_field("lockout_active", 32'(want.lockout_active),
                     32'(got.lockout_active));
         results_checked++;
         if (got.calib_request === 1'b1) calib_seen++;
         if (got.lockout_active === 1'b1) lockout_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && !req_chan.ready) input_stalls++;
         if (rsp_chan.valid && rsp_chan.ready) check_result(rsp_chan.data);
      end
   end

   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned tick;
      mode = 0;
      mode_left = 0;
      tick = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ((tick % 5) >= 2);
               default: rsp_chan.ready <= ((tick % 7) == 0);
            endcase
         end
      end
   end

   function automatic tmc_pkg::req_item_type make_item(
         input tmc_pkg::req_kind_type kind,
         input logic [tmc_pkg::TIME_W-1:0] t,
         input logic [tmc_pkg::MV_W-1:0] l,
         input logic [tmc_pkg::MV_W-1:0] r,
         input logic bl, input logic br);
      tmc_pkg::req_item_type it;
      it = '{kind, t, l, r, bl, br};
      return it;
   endfunction

   function automatic tmc_pkg::req_item_type random_item(
         input tmc_pkg::req_kind_type kind);
      tmc_pkg::req_item_type it;
      it.req_type = kind;
      it.time_ms = sim_now;
      it.left_mv = tmc_pkg::MV_W'($urandom_range(0, 4095));
      it.right_mv = tmc_pkg::MV_W'($urandom_range(0, 4095));
      it.left_pressed = 1'($urandom_range(0, 1));
      it.right_pressed = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Puts the sensor difference close to the deadband, on either side of it.
   function automatic tmc_pkg::req_item_type with_sensors(input tmc_pkg::req_item_type it);
      int band;
      int base;
      int delta;
      band = int'(motor_cfg.deadband_mv);
      case ($urandom_range(0, 3))
         0: delta = band;
         1: delta = band + 1;
         default: delta = $urandom_range(0, band + 40);
      endcase
      if ($urandom_range(0, 1) == 1) delta = -delta;
      base = $urandom_range(0, 4095);
      it.right_mv = tmc_pkg::MV_W'(base);
      base = base + delta;
      if (base < 0) base = 0;
      if (base > 4095) base = 4095;
      it.left_mv = tmc_pkg::MV_W'(base);
      return it;
   endfunction

   function automatic void advance_now(input int unsigned span);
      sim_now = sim_now + $urandom_range(0, span / 2 + 2);
   endfunction

   task automatic random_scenario();
      tmc_pkg::req_item_type it;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            send_item(with_sensors(random_item(tmc_pkg::REQ_AUTO)));
            repeat ($urandom_range(1, 4)) begin
               advance_now(motor_cfg.run_time_ms);
               send_item(random_item(tmc_pkg::REQ_TIMER));
            end
         end
         3, 4: begin
            repeat ($urandom_range(1, 5)) begin
               it = random_item(tmc_pkg::REQ_MANUAL);
               it.left_pressed = 1'b1;
               it.right_pressed = 1'b1;
               send_item(it);
               advance_now(motor_cfg.hold_time_ms);
            end
            repeat ($urandom_range(0, 2)) send_item(random_item(tmc_pkg::REQ_MANUAL));
            if ($urandom_range(0, 3) != 0) begin
               it = random_item(tmc_pkg::REQ_MANUAL);
               it.left_pressed = 1'b0;
               it.right_pressed = 1'b0;
               send_item(it);
            end
         end
         5, 6: begin
            send_item(random_item(tmc_pkg::REQ_MANUAL));
            advance_now(20);
         end
         7: begin
            send_item(random_item(tmc_pkg::REQ_AUTO));
            advance_now(motor_cfg.run_time_ms);
         end
         default: begin
            it = random_item(tmc_pkg::req_kind_type'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 1) it.time_ms = $urandom();
            send_item(it);
         end
      endcase
   endtask

   task automatic run_random_phase(input int count);
      int start;
      start = items_sent;
      sim_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 70000)
                                            : $urandom();
      while (items_sent - start < count) random_scenario();
   endtask

   task automatic test_reset_behavior();
      send_item(make_item(tmc_pkg::REQ_TIMER, 32'd0, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(REQ_UNUSED, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd1000, 12'd4095, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_TIMER, 32'd1499, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_TIMER, 32'd1500, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd2000, 12'd0, 12'd4095, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd2100, 12'd100, 12'd50, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd2200, 12'd100, 12'd49, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd2400, 12'd0, 12'd0, 1'b1, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd2500, 12'd0, 12'd0, 1'b0, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd2600, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd10000, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd12999, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd13000, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd13100, 12'd4095, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd13200, 12'd0, 12'd0, 1'b1, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd13300, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'hFFFF_FE0C, 12'd4095, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_TIMER, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'hFFFF_FF00, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd2743, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd2744, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd2800, 12'd0, 12'd0, 1'b0, 1'b0));
      wait_for_idle();
   endtask

   task automatic test_register_extremes();
      apply_settings(12'd0, 16'd0, 16'd0, 8'd255);
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd5, 12'd1, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_TIMER, 32'd5, 12'd0, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd0, 12'd0, 12'd1, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd7, 12'd0, 12'd0, 1'b1, 1'b1));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd8, 12'd0, 12'd0, 1'b0, 1'b0));
      wait_for_idle();
      apply_settings(12'd4095, 16'd65535, 16'd65535, 8'd0);
      send_item(make_item(tmc_pkg::REQ_AUTO, 32'd100, 12'd4095, 12'd0, 1'b0, 1'b0));
      send_item(make_item(tmc_pkg::REQ_MANUAL, 32'd150, 12'd0, 12'd0, 1'b0, 1'b1));
      wait_for_idle();
   endtask

   task automatic test_random_traffic(input int per_phase);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: apply_settings(tmc_pkg::MV_W'($urandom_range(0, 400)),
                              tmc_pkg::MS_W'($urandom_range(1, 2000)),
                              tmc_pkg::MS_W'($urandom_range(0, 3000)),
                              tmc_pkg::DUTY_W'($urandom_range(1, 255)));
            1: apply_settings(12'd0, 16'd0, 16'd0, 8'd255);
            2: apply_settings(12'd4095, 16'd65535, 16'd65535, 8'd0);
            default: apply_settings(tmc_pkg::MV_W'($urandom_range(0, 4095)),
                                    tmc_pkg::MS_W'($urandom_range(0, 65535)),
                                    tmc_pkg::MS_W'($urandom_range(0, 65535)),
                                    tmc_pkg::DUTY_W'($urandom_range(0, 255)));
         endcase
         run_random_phase(per_phase);
         wait_for_idle();
      end
   endtask

   task automatic test_backpressure();
      int start;
      apply_settings(tmc_pkg::MV_W'($urandom_range(0, 200)),
                     tmc_pkg::MS_W'($urandom_range(1, 1000)),
                     tmc_pkg::MS_W'($urandom_range(0, 2000)),
                     tmc_pkg::DUTY_W'($urandom_range(1, 255)));
      gaps_enabled = 1'b0;
      rsp_hold_cycles = 64;
      start = items_sent;
      sim_now = $urandom();
      while (items_sent - start < 24) random_scenario();
      gaps_enabled = 1'b1;
      wait_for_idle();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_we = 1'b0;
      csr_index = tmc_pkg::CSR_DEADBAND;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_behavior();
      test_register_extremes();
      test_random_traffic(150);
      test_backpressure();
      $display("Run covered %0d items (%0d timer, %0d auto, %0d manual, %0d unused code)",
               items_sent, kind_count[tmc_pkg::REQ_TIMER], kind_count[tmc_pkg::REQ_AUTO],
               kind_count[tmc_pkg::REQ_MANUAL], kind_count[REQ_UNUSED]);
      $display("under %0d register settings; %0d results, %0d calibration pulses, %0d %s",
               settings_applied, results_checked, calib_seen, input_stalls,
               "input stall cycles");
      if (mismatches == 0) begin
         $display("** tracker_motor_controller_top: PASSED **");
      end else begin
         $display("** tracker_motor_controller_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timeout with %0d results still expected.", pending_motor_results.size());
      $display("** tracker_motor_controller_top: FAILED **");
      $finish;
   end

endmodule
